FILE: hdl/bblur_pkg.sv
`default_nettype none

package bblur_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 1024;
  localparam int unsigned MAX_HEIGHT_DEF   = 4095;
  localparam int unsigned FRAME_WIDTH_RST  = 1024;
  localparam int unsigned FRAME_HEIGHT_RST = 768;

  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 12;
  localparam int unsigned CFG_DATA_W      = 12;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned RING_ROWS = 4;
  localparam int unsigned SLOT_W    = $clog2(RING_ROWS);

  // 9 * 255 fits in 12 bits; 2*sum + n fits in 13
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned DIVIDEND_W  = SUM_W + 1;
  localparam int unsigned CNT_N_W     = 4;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // one column of the four-row ring
  typedef pixel_t [RING_ROWS-1:0] ring_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FLUSH,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // ceil(2^18 / (2n)); exact floor for dividends below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_N_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bblur_in_if.sv
`default_nettype none

interface bblur_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [bblur_pkg::CHAN_W-1:0]  in_red;
  logic [bblur_pkg::CHAN_W-1:0]  in_green;
  logic [bblur_pkg::CHAN_W-1:0]  in_blue;

  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

FILE: hdl/bblur_out_if.sv
`default_nettype none

interface bblur_out_if;
  logic                          valid;
  logic                          ready;
  logic [bblur_pkg::CHAN_W-1:0]  out_red;
  logic [bblur_pkg::CHAN_W-1:0]  out_green;
  logic [bblur_pkg::CHAN_W-1:0]  out_blue;
  logic                          frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/box_blur_3x3_stream.sv
`default_nettype none

// Channel   Dir  Handshake     Payload
// in_bus    in   valid/ready   action, in_red, in_green, in_blue
// out_bus   out  valid/ready   out_red, out_green, out_blue, frame_end
// cfg_*     in   cfg_we        cfg_idx, cfg_data
//
// A pixel beat does a read-modify-write of its column word in the ring memory;
// a beat that yields a result (pixel, or drain without the write) goes on with three
// column reads on the single read port, one accumulate, one scale, one load.
// Synchronous reset clears control and counters; the ring memory is not cleared.
// The next beat is taken while a result waits; the block holds in its last step
// only if the output register is still full.
module box_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_data,
  bblur_in_if.sink                            in_bus,
  bblur_out_if.source                         out_bus
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW = $clog2(MAX_WIDTH + 3);
  localparam int unsigned SW = bblur_pkg::SLOT_W;
  localparam int unsigned CHW = bblur_pkg::CHAN_W;
  localparam int unsigned SUMW = bblur_pkg::SUM_W;
  localparam int unsigned DVW = bblur_pkg::DIVIDEND_W;
  localparam int unsigned NW = bblur_pkg::CNT_N_W;
  localparam int unsigned PW = bblur_pkg::PROD_W;

  localparam int unsigned WIDTH_RST =
    (bblur_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bblur_pkg::FRAME_WIDTH_RST;
  localparam int unsigned HEIGHT_RST =
    (bblur_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : bblur_pkg::FRAME_HEIGHT_RST;

  localparam logic [1:0] TAP_LEFT   = 2'd0;
  localparam logic [1:0] TAP_CENTER = 2'd1;
  localparam logic [1:0] TAP_RIGHT  = 2'd2;

  // ---------------------------------------------------------------- config
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [WW-1:0] cfg_w_val;
  logic [HW-1:0] cfg_h_val;
  logic [bblur_pkg::CFG_WIDTH_BITS-1:0]  cfg_w_raw;
  logic [bblur_pkg::CFG_HEIGHT_BITS-1:0] cfg_h_raw;

  assign cfg_w_raw = cfg_data[bblur_pkg::CFG_WIDTH_BITS-1:0];
  assign cfg_h_raw = cfg_data[bblur_pkg::CFG_HEIGHT_BITS-1:0];

  // zero acts as one, too large saturates
  always_comb begin
    if (cfg_w_raw == '0) begin
      cfg_w_val = WW'(1);
    end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
      cfg_w_val = WW'(MAX_WIDTH);
    end else begin
      cfg_w_val = WW'(cfg_w_raw);
    end
    if (cfg_h_raw == '0) begin
      cfg_h_val = HW'(1);
    end else if (32'(cfg_h_raw) > MAX_HEIGHT) begin
      cfg_h_val = HW'(MAX_HEIGHT);
    end else begin
      cfg_h_val = HW'(cfg_h_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(WIDTH_RST);
      height_r <= HW'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        bblur_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_w_val;
        bblur_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_h_val;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  bblur_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] in_col_r;
  logic [RW-1:0] in_row_r;
  logic          rx_done_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic          tx_done_r;
  logic [LW-1:0] lag_r;       // pixels received minus results given

  logic [CW-1:0]     wr_col_r;
  logic [SW-1:0]     wr_slot_r;
  bblur_pkg::pixel_t pix_r;
  logic              emit_r;

  logic [1:0]        rd_idx_r;
  logic              acc_vld_r;
  logic [1:0]        acc_idx_r;
  logic [SUMW-1:0]   sum_red_r, sum_green_r, sum_blue_r;
  logic [PW-1:0]     prod_red_r, prod_green_r, prod_blue_r;

  logic              out_valid_r;
  bblur_pkg::pixel_t out_pix_r;
  logic              out_end_r;

  // ---------------------------------------------------------------- input beat
  logic          in_rdy;
  logic          beat_acc;
  logic          pix_acc;
  logic          restart;
  logic [CW-1:0] pos_col;
  logic [RW-1:0] pos_row;
  logic          col_last_in;
  logic          row_last_in;
  logic          rx_done_new;
  logic [LW-1:0] lag_inc;
  logic          tx_done_base;
  logic          emit_pix;
  logic          emit_drain;

  assign beat_acc = in_bus.valid && in_rdy;
  assign pix_acc  = beat_acc && (in_bus.action == bblur_pkg::ACT_PIXEL);

  // a pixel after a complete frame opens the next one
  assign restart      = rx_done_r;
  assign pos_col      = restart ? '0 : in_col_r;
  assign pos_row      = restart ? '0 : in_row_r;
  assign col_last_in  = (WW'(pos_col) == width_r - WW'(1));
  assign row_last_in  = (HW'(pos_row) == height_r - HW'(1));
  assign rx_done_new  = col_last_in && row_last_in;
  assign lag_inc      = (restart ? '0 : lag_r) + LW'(1);
  assign tx_done_base = restart ? 1'b0 : tx_done_r;
  assign emit_pix     = !tx_done_base &&
                        (rx_done_new || (lag_inc >= LW'(width_r) + LW'(2)));
  assign emit_drain   = rx_done_r && !tx_done_r;

  // ---------------------------------------------------------------- output position
  logic          out_col_last;
  logic          out_row_last;
  logic          out_room;
  logic          emit_go;

  assign out_col_last = (WW'(out_col_r) == width_r - WW'(1));
  assign out_row_last = (HW'(out_row_r) == height_r - HW'(1));
  assign out_room     = !out_valid_r || out_bus.ready;
  assign emit_go      = (state_r == bblur_pkg::ST_EMIT) && out_room;

  // ---------------------------------------------------------------- ring memory
  logic                  mem_rd_en;
  logic [CW-1:0]         mem_rd_addr;
  logic                  mem_wr_en;
  bblur_pkg::ring_word_t mem_rd_data;
  bblur_pkg::ring_word_t mem_wr_data;
  logic [CW-1:0]         rd_col;

  // columns c-1, c, c+1; out-of-frame taps are read at a wrapped or unused address and masked
  assign rd_col = CW'(out_col_r + CW'(rd_idx_r) - CW'(1));

  always_comb begin
    mem_wr_data = mem_rd_data;
    mem_wr_data[wr_slot_r] = pix_r;
  end

  bblur_ring_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_col_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bblur_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_rdy      = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_col;
    mem_wr_en   = 1'b0;
    case (state_r)
      bblur_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_bus.valid) begin
          if (in_bus.action == bblur_pkg::ACT_PIXEL) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_col;
            state_nxt   = bblur_pkg::ST_WRITE;
          end else if (emit_drain) begin
            state_nxt = bblur_pkg::ST_READ;
          end
        end
      end
      bblur_pkg::ST_WRITE: begin
        mem_wr_en = 1'b1;
        state_nxt = emit_r ? bblur_pkg::ST_READ : bblur_pkg::ST_IDLE;
      end
      bblur_pkg::ST_READ: begin
        mem_rd_en = 1'b1;
        if (rd_idx_r == TAP_RIGHT) begin
          state_nxt = bblur_pkg::ST_FLUSH;
        end
      end
      bblur_pkg::ST_FLUSH: begin
        state_nxt = bblur_pkg::ST_SCALE;
      end
      bblur_pkg::ST_SCALE: begin
        state_nxt = bblur_pkg::ST_EMIT;
      end
      bblur_pkg::ST_EMIT: begin
        if (out_room) begin
          state_nxt = bblur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bblur_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_bus.ready = in_rdy;

  // ---------------------------------------------------------------- counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      rx_done_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      tx_done_r <= 1'b0;
      lag_r     <= '0;
      emit_r    <= 1'b0;
    end else if (cfg_we) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      rx_done_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      tx_done_r <= 1'b0;
      lag_r     <= '0;
    end else if (pix_acc) begin
      in_col_r  <= col_last_in ? '0 : pos_col + CW'(1);
      in_row_r  <= col_last_in ? pos_row + RW'(1) : pos_row;
      rx_done_r <= rx_done_new;
      lag_r     <= lag_inc;
      emit_r    <= emit_pix;
      if (restart) begin
        out_col_r <= '0;
        out_row_r <= '0;
        tx_done_r <= 1'b0;
      end
    end else if (emit_go) begin
      out_col_r <= out_col_last ? '0 : out_col_r + CW'(1);
      out_row_r <= out_col_last ? out_row_r + RW'(1) : out_row_r;
      tx_done_r <= out_col_last && out_row_last;
      lag_r     <= lag_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      wr_col_r  <= pos_col;
      wr_slot_r <= pos_row[SW-1:0];
      pix_r     <= '{red: in_bus.in_red, green: in_bus.in_green, blue: in_bus.in_blue};
    end
  end

  // ---------------------------------------------------------------- accumulate
  logic [SW-1:0]     slot_mid, slot_up, slot_dn;
  logic              up_ok, dn_ok, col_ok;
  bblur_pkg::pixel_t p_up, p_mid, p_dn;
  logic [SUMW-1:0]   add_red, add_green, add_blue;

  function automatic logic [SUMW-1:0] tap3(
    input logic [CHW-1:0] a,
    input logic [CHW-1:0] b,
    input logic [CHW-1:0] c,
    input logic           ea,
    input logic           eb,
    input logic           ec
  );
    logic [SUMW-1:0] s;
    s = (ea ? SUMW'(a) : '0) + (eb ? SUMW'(b) : '0) + (ec ? SUMW'(c) : '0);
    return s;
  endfunction

  assign slot_mid = out_row_r[SW-1:0];
  assign slot_up  = slot_mid - SW'(1);
  assign slot_dn  = slot_mid + SW'(1);
  assign up_ok    = (out_row_r != '0);
  assign dn_ok    = !out_row_last;
  assign p_up     = mem_rd_data[slot_up];
  assign p_mid    = mem_rd_data[slot_mid];
  assign p_dn     = mem_rd_data[slot_dn];

  always_comb begin
    case (acc_idx_r)
      TAP_LEFT:   col_ok = (out_col_r != '0);
      TAP_CENTER: col_ok = 1'b1;
      TAP_RIGHT:  col_ok = !out_col_last;
      default:    col_ok = 1'b0;
    endcase
  end

  assign add_red   = tap3(p_up.red, p_mid.red, p_dn.red,
                          col_ok && up_ok, col_ok, col_ok && dn_ok);
  assign add_green = tap3(p_up.green, p_mid.green, p_dn.green,
                          col_ok && up_ok, col_ok, col_ok && dn_ok);
  assign add_blue  = tap3(p_up.blue, p_mid.blue, p_dn.blue,
                          col_ok && up_ok, col_ok, col_ok && dn_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= TAP_LEFT;
      acc_vld_r <= 1'b0;
    end else begin
      rd_idx_r  <= (state_r == bblur_pkg::ST_READ) ? rd_idx_r + 2'd1 : TAP_LEFT;
      acc_vld_r <= (state_r == bblur_pkg::ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    acc_idx_r <= rd_idx_r;
    if (state_r == bblur_pkg::ST_IDLE || state_r == bblur_pkg::ST_WRITE) begin
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
    end else if (acc_vld_r) begin
      sum_red_r   <= sum_red_r + add_red;
      sum_green_r <= sum_green_r + add_green;
      sum_blue_r  <= sum_blue_r + add_blue;
    end
  end

  // ---------------------------------------------------------------- scale
  // mean = (2*sum + n) / (2n), done as a multiply by a rounded-up reciprocal
  logic [1:0]                      row_cnt, col_cnt;
  logic [NW-1:0]                   n_val;
  logic [bblur_pkg::RECIP_W-1:0]   recip_val;
  logic [DVW-1:0]                  dv_red, dv_green, dv_blue;

  assign row_cnt   = 2'd1 + {1'b0, up_ok} + {1'b0, dn_ok};
  assign col_cnt   = 2'd1 + {1'b0, out_col_r != '0} + {1'b0, !out_col_last};
  assign n_val     = NW'(row_cnt) * NW'(col_cnt);
  assign recip_val = bblur_pkg::recip(n_val);
  assign dv_red    = {sum_red_r, 1'b0} + DVW'(n_val);
  assign dv_green  = {sum_green_r, 1'b0} + DVW'(n_val);
  assign dv_blue   = {sum_blue_r, 1'b0} + DVW'(n_val);

  always_ff @(posedge clk) begin
    if (state_r == bblur_pkg::ST_SCALE) begin
      prod_red_r   <= PW'(dv_red) * PW'(recip_val);
      prod_green_r <= PW'(dv_green) * PW'(recip_val);
      prod_blue_r  <= PW'(dv_blue) * PW'(recip_val);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_pix_r.red   <= prod_red_r[bblur_pkg::RECIP_SHIFT +: CHW];
      out_pix_r.green <= prod_green_r[bblur_pkg::RECIP_SHIFT +: CHW];
      out_pix_r.blue  <= prod_blue_r[bblur_pkg::RECIP_SHIFT +: CHW];
      out_end_r       <= out_col_last && out_row_last;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_red   = out_pix_r.red;
  assign out_bus.out_green = out_pix_r.green;
  assign out_bus.out_blue  = out_pix_r.blue;
  assign out_bus.frame_end = out_end_r;

endmodule

`default_nettype wire

FILE: hdl/bblur_ring_mem.sv
`default_nettype none

// Column store of the four-row ring: one write port, one read port,
// read data registered.
module bblur_ring_mem #(
  parameter int unsigned DEPTH = bblur_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  bblur_pkg::ring_word_t   wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output bblur_pkg::ring_word_t   rd_data
);

  bblur_pkg::ring_word_t store_r [DEPTH];
  bblur_pkg::ring_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
